>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication assertion failed");

// Condition checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, cond) \
	label: assert property (@(posedge clk) (cond)) \
		else $error("invariant assertion failed");

`endif

>>> rtl/core/tnr_pkg.sv
// ----------------------------------------------------------------------------
// Telnet negotiation responder package
// Protocol codes, parser phase encoding, the job record passed from the front
// to the back, and the reply table.
// ----------------------------------------------------------------------------
package tnr_pkg;

	localparam logic [7:0] IAC          = 8'hFF;
	localparam logic [7:0] CMD_DONT     = 8'hFE;
	localparam logic [7:0] CMD_DO       = 8'hFD;
	localparam logic [7:0] CMD_WONT     = 8'hFC;
	localparam logic [7:0] CMD_WILL     = 8'hFB;
	localparam logic [7:0] CMD_SB       = 8'hFA;
	localparam logic [7:0] CMD_SE       = 8'hF0;
	localparam logic [7:0] OPT_ECHO     = 8'h01;
	localparam logic [7:0] OPT_LINEMODE = 8'h22;
	localparam logic [7:0] NO_REPLY     = 8'h00;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [4:0] {
		PH_SCAN    = 5'b00001,
		PH_IAC     = 5'b00010,
		PH_CMD     = 5'b00100,
		PH_SUB     = 5'b01000,
		PH_SUB_IAC = 5'b10000
	} phase_t;

	// One job describes all output octets caused by one accepted input octet.
	typedef struct packed {
		logic       is_data;
		logic       has_reply;
		logic       has_trailer;
		logic [7:0] value;
		logic [7:0] reply_cmd;
	} job_t;

	// Reply command for a command and option; NO_REPLY when none is due.
	function automatic logic [7:0] tnr_reply(input logic [7:0] cmd, input logic [7:0] opt);
		logic [7:0] r;
		r = NO_REPLY;
		if (cmd == CMD_DO) begin
			r = CMD_WILL;
		end else if (cmd == CMD_WONT) begin
			r = CMD_DONT;
		end else if (cmd == CMD_DONT) begin
			r = CMD_WONT;
		end
		if (opt == OPT_LINEMODE) begin
			if (cmd == CMD_DO || cmd == CMD_DONT) begin
				r = CMD_WONT;
			end else if (cmd == CMD_WILL || cmd == CMD_WONT) begin
				r = CMD_DONT;
			end
		end
		if (opt == OPT_ECHO) begin
			if (cmd == CMD_WILL || cmd == CMD_WONT) begin
				r = CMD_DONT;
			end else if (cmd == CMD_DO || cmd == CMD_DONT) begin
				r = CMD_WILL;
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/core/telnet_negotiation_responder_top.sv
// ----------------------------------------------------------------------------
// Telnet negotiation responder
// Passes terminal data octets through and answers telnet option negotiation
// with IAC replies, closing every command packet with IAC DONT LINEMODE.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake             Payload
//  -------  --------------------  --------------------------------------------
//  input    in_valid / in_stall   in_byte, first_of_packet, last_of_packet
//  output   out_valid / out_stall out_byte, to_terminal, response_last
//
// An input octet is accepted in every cycle while the job queue has room, so
// input runs at one transfer per cycle.
// The back end emits one output transfer per cycle while out_stall is low: a
// data octet gives one output octet, a reply three and a closing trailer three,
// so a packet end that also answers a command gives six output octets; the queue of
// QueueDepth jobs absorbs such bursts and the input stalls only when it fills.
// Reset is asynchronous and needs no clearing pass; the block is ready at once.
// The output is held in a register, so a stall on the output side does not
// stop input until the queue is full.
//
module telnet_negotiation_responder_top #(
	parameter int QueueDepth = tnr_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       first_of_packet,
	input  logic       last_of_packet,
	input  logic       in_valid,
	output logic       in_stall,
	output logic [7:0] out_byte,
	output logic       to_terminal,
	output logic       response_last,
	output logic       out_valid,
	input  logic       out_stall
);
	import tnr_pkg::*;

	// Jobs flow from the front end through the queue to the back end.
	logic q_full;
	logic push;
	job_t push_job;
	logic pop;
	logic head_valid;
	job_t head_job;

	// The front end classifies each octet and runs the command parser.
	tnr_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_byte         (in_byte),
		.first_of_packet (first_of_packet),
		.last_of_packet  (last_of_packet),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.q_full          (q_full),
		.push            (push),
		.push_job        (push_job)
	);

	// The queue lets the two halves stall independently of one another.
	tnr_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// The back end turns each job into its sequence of output octets.
	tnr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_job      (head_job),
		.pop           (pop),
		.out_byte      (out_byte),
		.to_terminal   (to_terminal),
		.response_last (response_last),
		.out_valid     (out_valid),
		.out_stall     (out_stall)
	);

endmodule

>>> rtl/core/tnr_front.sv
// ----------------------------------------------------------------------------
// Telnet negotiation responder front end
// Accepts received octets, tracks the packet kind and the command parser, and
// pushes one job per octet that causes output.
// ----------------------------------------------------------------------------
module tnr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       in_byte,
	input  logic             first_of_packet,
	input  logic             last_of_packet,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             q_full,
	output logic             push,
	output tnr_pkg::job_t    push_job
);
	import tnr_pkg::*;

	logic       packet_is_data_q;
	phase_t     phase_q;
	logic [7:0] held_command_q;

	logic       data_eff;
	phase_t     phase_eff;
	logic [7:0] held_eff;
	phase_t     phase_nx;
	logic [7:0] held_nx;
	logic [7:0] reply;
	logic       job_valid;
	logic       accept;
	phase_t     rescan_phase;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;
	assign push     = accept && job_valid;

	always_comb begin
		data_eff  = packet_is_data_q;
		phase_eff = phase_q;
		held_eff  = held_command_q;
		if (first_of_packet) begin
			data_eff  = (in_byte != IAC);
			phase_eff = PH_SCAN;
			held_eff  = 8'h00;
		end

		reply        = tnr_reply(held_eff, in_byte);
		rescan_phase = (in_byte == IAC) ? PH_IAC : PH_SCAN;

		phase_nx = phase_eff;
		held_nx  = held_eff;
		push_job = '0;
		push_job.value     = in_byte;
		push_job.reply_cmd = reply;

		if (data_eff) begin
			push_job.is_data = 1'b1;
			job_valid        = (in_byte != 8'h00);
		end else begin
			case (phase_eff)
				PH_IAC: begin
					if (in_byte == CMD_SB) begin
						phase_nx = PH_SUB;
					end else if (in_byte >= CMD_WILL && in_byte <= CMD_DONT) begin
						held_nx  = in_byte;
						phase_nx = PH_CMD;
					end else begin
						phase_nx = rescan_phase;
					end
				end
				PH_CMD: begin
					if (reply != NO_REPLY) begin
						push_job.has_reply = 1'b1;
						phase_nx           = PH_SCAN;
					end else begin
						phase_nx = rescan_phase;
					end
					held_nx = 8'h00;
				end
				PH_SUB: begin
					if (in_byte == IAC) begin
						phase_nx = PH_SUB_IAC;
					end
				end
				PH_SUB_IAC: begin
					if (in_byte == CMD_SE) begin
						phase_nx = PH_SCAN;
					end else if (in_byte != IAC) begin
						phase_nx = PH_SUB;
					end
				end
				default: begin
					phase_nx = rescan_phase;
				end
			endcase
			push_job.has_trailer = last_of_packet;
			job_valid = push_job.has_reply || last_of_packet;
		end

		if (last_of_packet) begin
			phase_nx = PH_SCAN;
			held_nx  = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_is_data_q <= 1'b0;
			phase_q          <= PH_SCAN;
			held_command_q   <= 8'h00;
		end else if (accept) begin
			packet_is_data_q <= data_eff;
			phase_q          <= phase_nx;
			held_command_q   <= held_nx;
		end
	end

endmodule

>>> rtl/core/tnr_queue.sv
// ----------------------------------------------------------------------------
// Telnet negotiation responder job queue
// Small first-in first-out store of jobs between the front and the back.
// ----------------------------------------------------------------------------
module tnr_queue #(
	parameter int Depth = tnr_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tnr_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output tnr_pkg::job_t head_job
);
	import tnr_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full       = (count_q == FullCnt);
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/tnr_back.sv
// ----------------------------------------------------------------------------
// Telnet negotiation responder back end
// Expands the job at the queue head into output octets, one per cycle while
// the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module tnr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  tnr_pkg::job_t head_job,
	output logic          pop,
	output logic [7:0]    out_byte,
	output logic          to_terminal,
	output logic          response_last,
	output logic          out_valid,
	input  logic          out_stall
);
	import tnr_pkg::*;

	localparam logic [2:0] STEP_REPLY_IAC = 3'd0;
	localparam logic [2:0] STEP_REPLY_CMD = 3'd1;
	localparam logic [2:0] STEP_REPLY_OPT = 3'd2;
	localparam logic [2:0] STEP_TRL_IAC   = 3'd3;
	localparam logic [2:0] STEP_TRL_CMD   = 3'd4;
	localparam logic [2:0] STEP_TRL_OPT   = 3'd5;

	logic [2:0] step_q;
	logic       started_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       to_terminal_q;
	logic       response_last_q;

	logic [2:0] cur_step;
	logic [2:0] end_step;
	logic       take;
	logic       job_done;
	logic [7:0] nx_byte;
	logic       nx_last;

	assign take = head_valid && (!out_valid_q || !out_stall);
	assign pop  = take && job_done;

	always_comb begin
		if (started_q) begin
			cur_step = step_q;
		end else begin
			cur_step = head_job.has_reply ? STEP_REPLY_IAC : STEP_TRL_IAC;
		end
		end_step = head_job.has_trailer ? STEP_TRL_OPT : STEP_REPLY_OPT;
		job_done = head_job.is_data || (cur_step == end_step);
		nx_last  = 1'b0;
		case (cur_step)
			STEP_REPLY_IAC: nx_byte = IAC;
			STEP_REPLY_CMD: nx_byte = head_job.reply_cmd;
			STEP_REPLY_OPT: nx_byte = head_job.value;
			STEP_TRL_IAC:   nx_byte = IAC;
			STEP_TRL_CMD:   nx_byte = CMD_DONT;
			STEP_TRL_OPT: begin
				nx_byte = OPT_LINEMODE;
				nx_last = 1'b1;
			end
			default:        nx_byte = IAC;
		endcase
		if (head_job.is_data) begin
			nx_byte = head_job.value;
			nx_last = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_REPLY_IAC;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				if (job_done) begin
					started_q <= 1'b0;
				end else begin
					started_q <= 1'b1;
					step_q    <= cur_step + 3'd1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q      <= nx_byte;
			to_terminal_q   <= head_job.is_data;
			response_last_q <= nx_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign to_terminal   = to_terminal_q;
	assign response_last = response_last_q;

endmodule

>>> rtl/core/tnr_checker.sv
// ----------------------------------------------------------------------------
// Telnet negotiation responder checker
// Port-level assertions on the responder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tnr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic [7:0] out_byte,
	input logic       to_terminal,
	input logic       response_last,
	input logic       out_valid,
	input logic       out_stall
);
	import tnr_pkg::*;

	logic       out_waiting;
	logic [9:0] out_payload;
	logic       trailer_end;

	assign out_waiting = out_valid && out_stall;
	assign out_payload = {out_byte, to_terminal, response_last};
	assign trailer_end = !to_terminal && (out_byte == OPT_LINEMODE);

	// A stalled output transfer keeps its payload.
	`ASSERT_IMPLIES(a_out_hold, clk, arst_n, $past(out_waiting), out_valid && $stable(out_payload))

	// The end of a response is always the linemode option octet.
	`ASSERT_IMPLIES(a_last_is_trailer, clk, arst_n, out_valid && response_last, trailer_end)

	// Zero octets of terminal data are never passed on.
	`ASSERT_IMPLIES(a_term_nonzero, clk, arst_n, out_valid && to_terminal, out_byte != 8'h00)

	// Under reset nothing is offered and input is not held off.
	`ASSERT_ALWAYS(a_reset_quiet, clk, arst_n || (!in_stall && !out_valid))

endmodule

bind telnet_negotiation_responder_top tnr_checker u_checker (.*);
